// ===== design/dpo_pkg.sv =====
// ----------------------------------------------------------------------------
// dpo_pkg: shared types and constants for the date period overlap counter
// Holds field widths, sequencer states, controller/datapath command and
// status bundles, and the month offset table.
// ----------------------------------------------------------------------------
package dpo_pkg;

  localparam int DayW    = 5;
  localparam int MonW    = 4;
  localparam int YearW   = 14;
  localparam int SerialW = 23;
  localparam int CountW  = 22;

  localparam logic [CountW-1:0] COUNT_MAX = '1;

  // 1311 / 2^15 stands in for 1/25; exact for dividends below 4681
  localparam int RecipShift = 15;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV_A,
    ST_CONV_B,
    ST_MINMAX,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       conv_a;
    logic       conv_b;
    logic [1:0] idx;
    logic       minmax;
    logic       finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

  function automatic logic [8:0] days_before_month(input logic [MonW-1:0] month);
    logic [8:0] days;
    case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

// ===== design/dpo_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpo_ctrl: sequencer for the date period overlap counter
// Steps the datapath through capture, two conversion steps per date,
// min/max selection and result load.
// ----------------------------------------------------------------------------
module dpo_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  dpo_pkg::dp_sts_t sts,
  output dpo_pkg::dp_cmd_t cmd
);
  import dpo_pkg::*;

  state_t     state, state_next;
  logic [1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= 2'd0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_CONV_A;
          idx_next   = 2'd0;
        end
      end
      ST_CONV_A: state_next = ST_CONV_B;
      ST_CONV_B: begin
        if (idx == 2'd3) begin
          state_next = ST_MINMAX;
        end else begin
          state_next = ST_CONV_A;
          idx_next   = idx + 2'd1;
        end
      end
      ST_MINMAX: state_next = ST_FINISH;
      ST_FINISH: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.idx  = idx;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CONV_A: cmd.conv_a = 1'b1;
      ST_CONV_B: cmd.conv_b = 1'b1;
      ST_MINMAX: cmd.minmax = 1'b1;
      ST_FINISH: cmd.finish = sts.out_free;
      default: in_stall = 1'b1;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_CONV_A && idx == 2'd0))
    else $error("accepted item did not start conversion at first date");

  a_last_date: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV_B && idx == 2'd3) |=> (state == ST_MINMAX))
    else $error("sequencer did not leave conversion after last date");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.out_free)
    else $error("result loaded while output register busy");

endmodule

// ===== design/dpo_datapath.sv =====
// ----------------------------------------------------------------------------
// dpo_datapath: date serial conversion, overlap count and output register
// Converts one date per two commands into a linear day serial, then picks
// the later start and earlier end and forms the inclusive count.
// ----------------------------------------------------------------------------
module dpo_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  dpo_pkg::dp_cmd_t            cmd,
  output dpo_pkg::dp_sts_t            sts,
  input  logic [dpo_pkg::DayW-1:0]    first_start_day,
  input  logic [dpo_pkg::MonW-1:0]    first_start_month,
  input  logic [dpo_pkg::YearW-1:0]   first_start_year,
  input  logic [dpo_pkg::DayW-1:0]    first_end_day,
  input  logic [dpo_pkg::MonW-1:0]    first_end_month,
  input  logic [dpo_pkg::YearW-1:0]   first_end_year,
  input  logic [dpo_pkg::DayW-1:0]    second_start_day,
  input  logic [dpo_pkg::MonW-1:0]    second_start_month,
  input  logic [dpo_pkg::YearW-1:0]   second_start_year,
  input  logic [dpo_pkg::DayW-1:0]    second_end_day,
  input  logic [dpo_pkg::MonW-1:0]    second_end_month,
  input  logic [dpo_pkg::YearW-1:0]   second_end_year,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dpo_pkg::CountW-1:0]  overlap_days,
  output logic                        overlaps
);
  import dpo_pkg::*;

  // captured dates: 0 first start, 1 first end, 2 second start, 3 second end
  logic [DayW-1:0]    day_q   [4];
  logic [MonW-1:0]    month_q [4];
  logic [YearW-1:0]   year_q  [4];
  logic [SerialW-1:0] ser     [4];

  // step A registers
  logic [YearW-1:0]   a_year;
  logic [MonW-1:0]    a_mon;
  logic [DayW-1:0]    a_day;
  logic [SerialW-1:0] a_y365;
  logic [22:0]        a_p100;
  logic [20:0]        a_p400;
  logic [22:0]        a_pw;

  logic [SerialW-1:0] lo, hi;

  // step A combinational
  logic [YearW-1:0]   sel_year;
  logic [MonW-1:0]    sel_mon;
  logic [MonW-1:0]    mon_clamp;
  logic [14:0]        y99, y399;
  logic [SerialW-1:0] y365;
  logic [22:0]        p100;
  logic [20:0]        p400;
  logic [22:0]        pw;

  always_comb begin
    sel_year = year_q[cmd.idx];
    sel_mon  = month_q[cmd.idx];
    if (sel_mon == 4'd0) begin
      mon_clamp = 4'd1;
    end else if (sel_mon > 4'd12) begin
      mon_clamp = 4'd12;
    end else begin
      mon_clamp = sel_mon;
    end
    y99  = {1'b0, sel_year} + 15'd99;
    y399 = {1'b0, sel_year} + 15'd399;
    y365 = {9'd0, sel_year} * 23'd365;
    p100 = {10'd0, y99[14:2]} * 23'd1311;
    p400 = {10'd0, y399[14:4]} * 21'd1311;
    pw   = {11'd0, sel_year[13:2]} * 23'd1311;
  end

  // step B combinational
  logic [7:0]         q100, qw;
  logic [5:0]         q400;
  logic [14:0]        yp3;
  logic [12:0]        leaps;
  logic [11:0]        qw25;
  logic               leap, late_leap;
  logic [SerialW-1:0] serial;

  always_comb begin
    q100      = a_p100[22:RecipShift];
    q400      = a_p400[20:RecipShift];
    qw        = a_pw[22:RecipShift];
    yp3       = {1'b0, a_year} + 15'd3;
    leaps     = yp3[14:2] - {5'd0, q100} + {7'd0, q400};
    qw25      = {4'd0, qw} * 12'd25;
    // divisible by 4, and either not by 100 or by 400 as well
    leap      = (a_year[1:0] == 2'd0) &&
                ((qw25 != a_year[13:2]) || (a_year[3:0] == 4'd0));
    late_leap = leap && (a_mon > 4'd2);
    serial    = a_y365 + {10'd0, leaps} + {14'd0, days_before_month(a_mon)}
              + {22'd0, late_leap} + {18'd0, a_day};
  end

  // count
  logic [SerialW:0] span;
  logic             hit;
  logic [CountW-1:0] count;

  always_comb begin
    hit  = (lo <= hi);
    span = {1'b0, hi} - {1'b0, lo} + 24'd1;
    if (!hit) begin
      count = '0;
    end else if (span > {2'd0, COUNT_MAX}) begin
      count = COUNT_MAX;
    end else begin
      count = span[CountW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day_q[0]   <= first_start_day;
      month_q[0] <= first_start_month;
      year_q[0]  <= first_start_year;
      day_q[1]   <= first_end_day;
      month_q[1] <= first_end_month;
      year_q[1]  <= first_end_year;
      day_q[2]   <= second_start_day;
      month_q[2] <= second_start_month;
      year_q[2]  <= second_start_year;
      day_q[3]   <= second_end_day;
      month_q[3] <= second_end_month;
      year_q[3]  <= second_end_year;
    end
    if (cmd.conv_a) begin
      a_year <= sel_year;
      a_mon  <= mon_clamp;
      a_day  <= day_q[cmd.idx];
      a_y365 <= y365;
      a_p100 <= p100;
      a_p400 <= p400;
      a_pw   <= pw;
    end
    if (cmd.conv_b) begin
      ser[cmd.idx] <= serial;
    end
    if (cmd.minmax) begin
      lo <= (ser[0] > ser[2]) ? ser[0] : ser[2];
      hi <= (ser[1] < ser[3]) ? ser[1] : ser[3];
    end
    if (cmd.finish) begin
      overlap_days <= count;
      overlaps     <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_free = !out_valid || !out_stall;

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("loaded result not presented");

  a_flag_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (overlaps == (overlap_days != '0)))
    else $error("overlap flag disagrees with count");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.finish)
    else $error("stalled result overwritten");

endmodule

// ===== design/date_period_overlap_days.sv =====
// ----------------------------------------------------------------------------
// date_period_overlap_days: inclusive day overlap of two Gregorian periods
// Maps each of four dates to a linear day serial, then counts the days
// shared by both periods and flags whether any day is shared.
// ----------------------------------------------------------------------------
//
//   channel  handshake            payload
//   input    in_valid / in_stall  first_* and second_* day, month, year
//   output   out_valid/out_stall  overlap_days, overlaps
//
// An item is accepted in the idle cycle, which also captures its dates. After
// acceptance, the shared serial converter takes each of the four dates through
// step A and step B in turn; a min/max step and a count step then form the result.
// A new item is taken once the previous result sits in the output register.
// Reset (rst, synchronous) clears the sequencer and the output valid.
// A stalled output holds the result; the sequencer waits before loading the next.
module date_period_overlap_days (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [dpo_pkg::DayW-1:0]    first_start_day,
  input  logic [dpo_pkg::MonW-1:0]    first_start_month,
  input  logic [dpo_pkg::YearW-1:0]   first_start_year,
  input  logic [dpo_pkg::DayW-1:0]    first_end_day,
  input  logic [dpo_pkg::MonW-1:0]    first_end_month,
  input  logic [dpo_pkg::YearW-1:0]   first_end_year,
  input  logic [dpo_pkg::DayW-1:0]    second_start_day,
  input  logic [dpo_pkg::MonW-1:0]    second_start_month,
  input  logic [dpo_pkg::YearW-1:0]   second_start_year,
  input  logic [dpo_pkg::DayW-1:0]    second_end_day,
  input  logic [dpo_pkg::MonW-1:0]    second_end_month,
  input  logic [dpo_pkg::YearW-1:0]   second_end_year,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dpo_pkg::CountW-1:0]  overlap_days,
  output logic                        overlaps
);
  import dpo_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  dpo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dpo_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .first_start_day    (first_start_day),
    .first_start_month  (first_start_month),
    .first_start_year   (first_start_year),
    .first_end_day      (first_end_day),
    .first_end_month    (first_end_month),
    .first_end_year     (first_end_year),
    .second_start_day   (second_start_day),
    .second_start_month (second_start_month),
    .second_start_year  (second_start_year),
    .second_end_day     (second_end_day),
    .second_end_month   (second_end_month),
    .second_end_year    (second_end_year),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .overlap_days       (overlap_days),
    .overlaps           (overlaps)
  );

endmodule

// ===== tb/sv/date_period_overlap_days_tb.sv =====
// ----------------------------------------------------------------------------
// date_period_overlap_days_tb: self-checking bench for the period overlap counter
// Drives pairs of date periods through the valid/stall input channel, predicts
// the inclusive overlap count and flag from linear day numbers, and checks each
// result in order. Runs a directed set, then random items under several idling
// mixes on both channels, draining the block between phases.
// ----------------------------------------------------------------------------
module date_period_overlap_days_tb;
  import dpo_pkg::*;

  typedef struct packed {
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
  } date_t;

  typedef struct packed {
    date_t first_start;
    date_t first_end;
    date_t second_start;
    date_t second_end;
  } period_pair_t;

  typedef struct packed {
    logic [CountW-1:0] days;
    logic              overlaps;
  } overlap_t;

  localparam int StallLimit  = 4000;
  localparam int RandomItems = 1900;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [CountW-1:0] overlap_days;
  logic         overlaps;
  period_pair_t bus_pair = '0;

  period_pair_t pending_items[$];
  overlap_t     expected_overlaps[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  error_count = 0;
  int unsigned  quiet_cycles = 0;

  date_period_overlap_days u_top (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .first_start_day    (bus_pair.first_start.day),
    .first_start_month  (bus_pair.first_start.month),
    .first_start_year   (bus_pair.first_start.year),
    .first_end_day      (bus_pair.first_end.day),
    .first_end_month    (bus_pair.first_end.month),
    .first_end_year     (bus_pair.first_end.year),
    .second_start_day   (bus_pair.second_start.day),
    .second_start_month (bus_pair.second_start.month),
    .second_start_year  (bus_pair.second_start.year),
    .second_end_day     (bus_pair.second_end.day),
    .second_end_month   (bus_pair.second_end.month),
    .second_end_year    (bus_pair.second_end.year),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .overlap_days       (overlap_days),
    .overlaps           (overlaps)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
    case (m)
      2:           return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Linear day number; January 1 of year 0 is 1. Month is clamped to 1..12,
  // the day is added as is.
  function automatic int unsigned day_number(input date_t dt);
    int unsigned m;
    int unsigned y;
    int unsigned n;
    m = dt.month;
    y = dt.year;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned k = 1; k < m; k++) n += month_length(k, y);
    return n + dt.day;
  endfunction

  function automatic overlap_t overlap_of(input period_pair_t p);
    int unsigned s1, e1, s2, e2, lo, hi, n;
    overlap_t r;
    s1 = day_number(p.first_start);
    e1 = day_number(p.first_end);
    s2 = day_number(p.second_start);
    e2 = day_number(p.second_end);
    lo = (s1 > s2) ? s1 : s2;
    hi = (e1 < e2) ? e1 : e2;
    n = 0;
    if (lo <= hi) n = hi - lo + 1;
    if (n > COUNT_MAX) n = COUNT_MAX;
    r.days = n[CountW-1:0];
    r.overlaps = (n != 0);
    return r;
  endfunction

  function automatic date_t mk_date(input int unsigned d, input int unsigned m,
                                    input int unsigned y);
    date_t r;
    r.day = d[DayW-1:0];
    r.month = m[MonW-1:0];
    r.year = y[YearW-1:0];
    return r;
  endfunction

  task automatic queue_pair(input date_t a, input date_t b, input date_t c, input date_t e);
    period_pair_t p;
    p.first_start = a;
    p.first_end = b;
    p.second_start = c;
    p.second_end = e;
    pending_items.push_back(p);
  endtask

  function automatic int unsigned pick_year();
    int unsigned centuries[8] = '{100, 400, 1600, 1900, 2000, 2100, 2400, 9600};
    case ($urandom_range(0, 9))
      0:       return centuries[$urandom_range(0, 7)];
      1:       return $urandom_range(0, 1) ? 1 : 9999;
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  function automatic int unsigned near_year(input int unsigned y, input int unsigned spread);
    int v;
    v = $urandom_range(0, 2 * spread);
    v = v + int'(y) - int'(spread);
    if (v < 1) v = 1;
    if (v > 9999) v = 9999;
    return v;
  endfunction

  function automatic date_t valid_date(input int unsigned y);
    date_t r;
    int unsigned m;
    m = $urandom_range(1, 12);
    r.year = y[YearW-1:0];
    r.month = m[MonW-1:0];
    case ($urandom_range(0, 3))
      0:       r.day = DayW'(month_length(m, y));
      1:       r.day = DayW'(1);
      default: r.day = DayW'($urandom_range(1, month_length(m, y)));
    endcase
    return r;
  endfunction

  function automatic date_t noise_date();
    date_t r;
    r.day = DayW'($urandom);
    r.month = MonW'($urandom);
    r.year = YearW'($urandom);
    return r;
  endfunction

  // Mostly well-formed periods close together in time; some touch on one day,
  // a fifth are raw bit noise.
  function automatic period_pair_t random_pair();
    period_pair_t p;
    date_t tmp;
    int unsigned y;
    int unsigned spread;
    y = pick_year();
    spread = ($urandom_range(0, 3) == 0) ? 40 : 1;
    p.first_start = valid_date(near_year(y, spread));
    p.first_end = valid_date(near_year(y, spread));
    p.second_start = valid_date(near_year(y, spread));
    p.second_end = valid_date(near_year(y, spread));
    // order most periods; leave some reversed
    if ($urandom_range(0, 3) != 0 && day_number(p.first_start) > day_number(p.first_end)) begin
      tmp = p.first_start;
      p.first_start = p.first_end;
      p.first_end = tmp;
    end
    if ($urandom_range(0, 3) != 0 && day_number(p.second_start) > day_number(p.second_end)) begin
      tmp = p.second_start;
      p.second_start = p.second_end;
      p.second_end = tmp;
    end
    case ($urandom_range(0, 9))
      7: begin
        p.second_start = p.first_end;
      end
      8, 9: begin
        p.first_start = noise_date();
        p.first_end = noise_date();
        p.second_start = noise_date();
        p.second_end = noise_date();
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_overlaps.size() != 0);
  endtask

  // sender: hold a stalled item, otherwise advance or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_overlaps.push_back(overlap_of(bus_pair));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          bus_pair <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    overlap_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_overlaps.size() == 0) begin
          $error("overlap result with no item pending: overlap_days %0d", overlap_days);
          error_count++;
        end else begin
          want = expected_overlaps.pop_front();
          if (overlap_days !== want.days) begin
            $error("overlap_days: expected %0d, got %0d", want.days, overlap_days);
            error_count++;
          end
          if (overlaps !== want.overlaps) begin
            $error("overlaps: expected %0b, got %0b", want.overlaps, overlaps);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("date_period_overlap_days regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single common day
    queue_pair(mk_date(1, 1, 2024), mk_date(1, 1, 2024), mk_date(1, 1, 2024), mk_date(1, 1, 2024));
    // whole valid range on both sides
    queue_pair(mk_date(1, 1, 1), mk_date(31, 12, 9999), mk_date(1, 1, 1), mk_date(31, 12, 9999));
    // disjoint years
    queue_pair(mk_date(1, 1, 2020), mk_date(31, 12, 2020), mk_date(1, 1, 2021), mk_date(31, 12, 2021));
    // far apart, second before first
    queue_pair(mk_date(1, 1, 9999), mk_date(31, 12, 9999), mk_date(1, 1, 1), mk_date(31, 12, 1));
    // touching on one day
    queue_pair(mk_date(1, 3, 2019), mk_date(15, 6, 2019), mk_date(15, 6, 2019), mk_date(1, 9, 2019));
    // reversed first period, then reversed second
    queue_pair(mk_date(10, 5, 2010), mk_date(9, 5, 2010), mk_date(1, 1, 2010), mk_date(31, 12, 2010));
    queue_pair(mk_date(1, 1, 2010), mk_date(31, 12, 2010), mk_date(10, 5, 2010), mk_date(9, 5, 2010));
    // containment across a leap day
    queue_pair(mk_date(1, 1, 1990), mk_date(31, 12, 1999), mk_date(28, 2, 1996), mk_date(1, 3, 1996));
    // partial overlap across years
    queue_pair(mk_date(1, 7, 1999), mk_date(30, 6, 2001), mk_date(1, 1, 2000), mk_date(31, 12, 2005));
    // century rule: 1900 plain, 2000 leap, 2100 plain with a Feb 29 that rolls over
    queue_pair(mk_date(28, 2, 1900), mk_date(1, 3, 1900), mk_date(28, 2, 1900), mk_date(1, 3, 1900));
    queue_pair(mk_date(28, 2, 2000), mk_date(1, 3, 2000), mk_date(28, 2, 2000), mk_date(1, 3, 2000));
    queue_pair(mk_date(29, 2, 2100), mk_date(1, 3, 2100), mk_date(1, 3, 2100), mk_date(2, 3, 2100));
    // month zero and months past December
    queue_pair(mk_date(5, 0, 2015), mk_date(5, 15, 2015), mk_date(1, 1, 2015), mk_date(31, 12, 2015));
    queue_pair(mk_date(1, 13, 2016), mk_date(31, 14, 2016), mk_date(1, 12, 2016), mk_date(31, 12, 2016));
    // day zero and day 31 of a 30-day month
    queue_pair(mk_date(0, 3, 2021), mk_date(31, 4, 2021), mk_date(28, 2, 2021), mk_date(1, 5, 2021));
    // year zero
    queue_pair(mk_date(1, 1, 0), mk_date(31, 12, 0), mk_date(0, 0, 0), mk_date(31, 12, 1));
    // count saturates, then a large overlap in years past 9999
    queue_pair(mk_date(0, 0, 0), mk_date(31, 15, 16383), mk_date(0, 0, 0), mk_date(31, 15, 16383));
    queue_pair(mk_date(1, 1, 10000), mk_date(31, 12, 16383), mk_date(0, 0, 0), mk_date(31, 15, 16383));
    // all fields at their top and bottom codes
    queue_pair(mk_date(31, 15, 16383), mk_date(31, 15, 16383), mk_date(31, 15, 16383),
               mk_date(31, 15, 16383));
    queue_pair(mk_date(0, 0, 0), mk_date(0, 0, 0), mk_date(0, 0, 0), mk_date(0, 0, 0));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      for (int n = 0; n < RandomItems / 4; n++) pending_items.push_back(random_pair());
      // hold off the next phase until every result is back
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("date_period_overlap_days regression: pass");
    end else begin
      $display("date_period_overlap_days regression: fail");
    end
    $finish;
  end

endmodule
